FILE: design/ica_pkg.sv
// Shared package for the integer calculator ALU.
// Holds the operation and status codes, and the command and status structs
// that pass between the controller and the datapath. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ica_pkg;

    localparam int DEFAULT_WIDTH = 32;

    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int FIELD_W = 32;

    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POW  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FACT = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DIV0 = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NEG  = 2'd2;

    typedef enum logic [3:0] {
        DP_NONE      = 4'd0,
        DP_ADD       = 4'd1,
        DP_SUB       = 4'd2,
        DP_ZERO      = 4'd3,
        DP_ERR_DIV0  = 4'd4,
        DP_ERR_NEG   = 4'd5,
        DP_DIV_INIT  = 4'd6,
        DP_DIV_STEP  = 4'd7,
        DP_DIV_FIX   = 4'd8,
        DP_POW_INIT  = 4'd9,
        DP_FACT_INIT = 4'd10,
        DP_MUL_ACC   = 4'd11,
        DP_POW_SQ    = 4'd12,
        DP_FACT_NEXT = 4'd13
    } t_dp_op;

    typedef enum logic [1:0] {
        MS_AB      = 2'd0,
        MS_ACC_SQ  = 2'd1,
        MS_SQ_SQ   = 2'd2,
        MS_ACC_CNT = 2'd3
    } t_mul_src;

    typedef struct packed {
        logic     load;
        t_dp_op   op;
        logic     mul_start;
        t_mul_src mul_src;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic opa_neg;
        logic opb_neg;
        logic opb_zero;
        logic cnt_zero;
        logic cnt_lsb;
        logic fact_end;
        logic mul_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: design/integer_calculator_alu.sv
// Integer calculator ALU top level: add, subtract, multiply, divide, power, factorial.
// Add and subtract are computed in the setup state. Multiply takes one multiplier bit per cycle,
// finishing early once the remaining bits are zero; divide takes one quotient bit per cycle;
// power and factorial run one serial multiply per multiplication: one squaring per exponent
// bit plus one more for each set bit, or one per factorial term until the term passes the operand.
// One request at a time; synchronous active-low reset clears only the state, valid and multiplier busy flags.
`timescale 1ns / 1ps
`default_nettype none

module integer_calculator_alu #(
    parameter int WIDTH = ica_pkg::DEFAULT_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [ica_pkg::KIND_W-1:0]         i_kind,
    input  wire logic signed [ica_pkg::FIELD_W-1:0] i_operand_a,
    input  wire logic signed [ica_pkg::FIELD_W-1:0] i_operand_b,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [ica_pkg::FIELD_W-1:0]      o_result,
    output logic signed [ica_pkg::FIELD_W-1:0]      o_remainder_out,
    output logic [ica_pkg::STAT_W-1:0]              o_status
);

    import ica_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [WIDTH-1:0]  opa_w;
    logic [WIDTH-1:0]  opb_w;
    logic [WIDTH-1:0]  res_w;
    logic [WIDTH-1:0]  rem_w;

    assign opa_w = WIDTH'(i_operand_a);
    assign opb_w = WIDTH'(i_operand_b);

    ica_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_kind (i_kind),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    ica_dpath #(
        .WIDTH(WIDTH)
    ) u_dpath (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_opa  (opa_w),
        .i_opb  (opb_w),
        .o_sts  (sts),
        .o_res  (res_w),
        .o_rem  (rem_w),
        .o_stat (o_status)
    );

    assign o_result        = FIELD_W'(signed'(res_w));
    assign o_remainder_out = FIELD_W'(signed'(rem_w));

endmodule

`default_nettype wire

FILE: design/ica_mul.sv
// Shift-and-add multiplier that keeps the low WIDTH bits of the product.
// One multiplier bit per cycle, finishing early once the remaining bits are zero.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module ica_mul #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_prod
);

    logic             r_busy, n_busy;
    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [WIDTH-1:0] r_p, n_p;

    assign o_done = r_busy && (r_y == '0);
    assign o_prod = r_p;

    always_comb begin
        n_busy = r_busy;
        n_x    = r_x;
        n_y    = r_y;
        n_p    = r_p;
        if (i_start) begin
            n_busy = 1'b1;
            n_x    = i_x;
            n_y    = i_y;
            n_p    = '0;
        end else if (r_busy) begin
            if (r_y == '0) begin
                n_busy = 1'b0;
            end else begin
                if (r_y[0]) begin
                    n_p = r_p + r_x;
                end
                n_x = {r_x[WIDTH-2:0], 1'b0};
                n_y = {1'b0, r_y[WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_p <= n_p;
    end

endmodule

`default_nettype wire

FILE: design/ica_dpath.sv
// Datapath of the integer calculator ALU: operand, work and output registers,
// the restoring divider step and the shared serial multiplier.
// Depends on ica_pkg and ica_mul.
`timescale 1ns / 1ps
`default_nettype none

module ica_dpath #(
    parameter int WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ica_pkg::t_cmd              i_cmd,
    input  wire logic [WIDTH-1:0]           i_opa,
    input  wire logic [WIDTH-1:0]           i_opb,
    output ica_pkg::t_sts                   o_sts,
    output logic [WIDTH-1:0]                o_res,
    output logic [WIDTH-1:0]                o_rem,
    output logic [ica_pkg::STAT_W-1:0]      o_stat
);

    import ica_pkg::*;

    logic [WIDTH-1:0]  r_opa, n_opa;
    logic [WIDTH-1:0]  r_opb, n_opb;
    logic [WIDTH-1:0]  r_acc, n_acc;
    logic [WIDTH-1:0]  r_sq, n_sq;
    logic [WIDTH-1:0]  r_cnt, n_cnt;
    logic [WIDTH-1:0]  r_rem, n_rem;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic [WIDTH-1:0]  r_out_res;
    logic [WIDTH-1:0]  r_out_rem;
    logic [STAT_W-1:0] r_out_stat;

    logic             opa_neg;
    logic             opb_neg;
    logic [WIDTH-1:0] opa_mag;
    logic [WIDTH-1:0] opb_mag;
    logic [WIDTH-1:0] trial;
    logic [WIDTH-1:0] mul_x;
    logic [WIDTH-1:0] mul_y;
    logic             mul_done;
    logic [WIDTH-1:0] mul_prod;

    assign opa_neg = r_opa[WIDTH-1];
    assign opb_neg = r_opb[WIDTH-1];
    assign opa_mag = opa_neg ? (~r_opa + WIDTH'(1)) : r_opa;
    assign opb_mag = opb_neg ? (~r_opb + WIDTH'(1)) : r_opb;
    assign trial   = {r_rem[WIDTH-2:0], r_acc[WIDTH-1]};

    always_comb begin
        case (i_cmd.mul_src)
            MS_AB: begin
                mul_x = r_opa;
                mul_y = r_opb;
            end
            MS_ACC_SQ: begin
                mul_x = r_acc;
                mul_y = r_sq;
            end
            MS_SQ_SQ: begin
                mul_x = r_sq;
                mul_y = r_sq;
            end
            default: begin
                mul_x = r_acc;
                mul_y = r_cnt;
            end
        endcase
    end

    ica_mul #(
        .WIDTH(WIDTH)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.mul_start),
        .i_x    (mul_x),
        .i_y    (mul_y),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    always_comb begin
        n_opa  = r_opa;
        n_opb  = r_opb;
        n_acc  = r_acc;
        n_sq   = r_sq;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_stat = r_stat;
        if (i_cmd.load) begin
            n_opa  = i_opa;
            n_opb  = i_opb;
            n_rem  = '0;
            n_stat = STAT_OK;
        end
        unique case (i_cmd.op)
            DP_NONE: begin
            end
            DP_ADD: begin
                n_acc = r_opa + r_opb;
            end
            DP_SUB: begin
                n_acc = r_opa - r_opb;
            end
            DP_ZERO: begin
                n_acc = '0;
            end
            DP_ERR_DIV0: begin
                n_acc  = '0;
                n_stat = STAT_DIV0;
            end
            DP_ERR_NEG: begin
                n_acc  = '0;
                n_stat = STAT_NEG;
            end
            DP_DIV_INIT: begin
                n_acc = opa_mag;
                n_sq  = opb_mag;
                n_rem = '0;
                n_cnt = WIDTH'(WIDTH - 1);
            end
            DP_DIV_STEP: begin
                if (trial >= r_sq) begin
                    n_rem = trial - r_sq;
                    n_acc = {r_acc[WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_acc = {r_acc[WIDTH-2:0], 1'b0};
                end
                n_cnt = r_cnt - WIDTH'(1);
            end
            DP_DIV_FIX: begin
                n_acc = (opa_neg ^ opb_neg) ? (~r_acc + WIDTH'(1)) : r_acc;
                n_rem = opa_neg ? (~r_rem + WIDTH'(1)) : r_rem;
            end
            DP_POW_INIT: begin
                n_acc = WIDTH'(1);
                n_sq  = r_opa;
                n_cnt = r_opb;
            end
            DP_FACT_INIT: begin
                n_acc = WIDTH'(1);
                n_sq  = r_opa;
                n_cnt = WIDTH'(1);
            end
            DP_MUL_ACC: begin
                n_acc = mul_prod;
            end
            DP_POW_SQ: begin
                n_sq  = mul_prod;
                n_cnt = {1'b0, r_cnt[WIDTH-1:1]};
            end
            DP_FACT_NEXT: begin
                n_acc = mul_prod;
                n_cnt = r_cnt + WIDTH'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_opa  <= n_opa;
        r_opb  <= n_opb;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_stat <= n_stat;
        if (i_cmd.out_load) begin
            r_out_res  <= r_acc;
            r_out_rem  <= r_rem;
            r_out_stat <= r_stat;
        end
    end

    assign o_sts.opa_neg  = opa_neg;
    assign o_sts.opb_neg  = opb_neg;
    assign o_sts.opb_zero = (r_opb == '0);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_lsb  = r_cnt[0];
    assign o_sts.fact_end = (r_cnt > r_sq) || (r_acc == '0);
    assign o_sts.mul_done = mul_done;

    assign o_res  = r_out_res;
    assign o_rem  = r_out_rem;
    assign o_stat = r_out_stat;

endmodule

`default_nettype wire

FILE: design/ica_ctrl.sv
// Controller of the integer calculator ALU: request handshake, operation
// sequencing and the output valid flag. Drives the datapath by command struct.
// Depends on ica_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ica_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [ica_pkg::KIND_W-1:0] i_kind,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    input  wire ica_pkg::t_sts              i_sts,
    output ica_pkg::t_cmd                   o_cmd
);

    import ica_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SETUP    = 11'b000_0000_0010,
        S_MUL      = 11'b000_0000_0100,
        S_DIV      = 11'b000_0000_1000,
        S_DIV_FIX  = 11'b000_0001_0000,
        S_POW_CHK  = 11'b000_0010_0000,
        S_POW_MUL  = 11'b000_0100_0000,
        S_POW_SQ   = 11'b000_1000_0000,
        S_FACT_CHK = 11'b001_0000_0000,
        S_FACT_MUL = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_out_valid = r_out_valid;
        o_cmd.load      = 1'b0;
        o_cmd.op        = DP_NONE;
        o_cmd.mul_start = 1'b0;
        o_cmd.mul_src   = MS_AB;
        o_cmd.out_load  = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_kind     = i_kind;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_DONE;
                unique case (r_kind)
                    KIND_ADD: o_cmd.op = DP_ADD;
                    KIND_SUB: o_cmd.op = DP_SUB;
                    KIND_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.mul_src   = MS_AB;
                        n_state         = S_MUL;
                    end
                    KIND_DIV: begin
                        if (i_sts.opb_zero) begin
                            o_cmd.op = DP_ERR_DIV0;
                        end else begin
                            o_cmd.op = DP_DIV_INIT;
                            n_state  = S_DIV;
                        end
                    end
                    KIND_POW: begin
                        if (i_sts.opb_neg) begin
                            o_cmd.op = DP_ERR_NEG;
                        end else begin
                            o_cmd.op = DP_POW_INIT;
                            n_state  = S_POW_CHK;
                        end
                    end
                    KIND_FACT: begin
                        if (i_sts.opa_neg) begin
                            o_cmd.op = DP_ERR_NEG;
                        end else begin
                            o_cmd.op = DP_FACT_INIT;
                            n_state  = S_FACT_CHK;
                        end
                    end
                    default: o_cmd.op = DP_ZERO;
                endcase
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.op = DP_MUL_ACC;
                    n_state  = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_sts.cnt_zero) begin
                    n_state = S_DIV_FIX;
                end
            end
            S_DIV_FIX: begin
                o_cmd.op = DP_DIV_FIX;
                n_state  = S_DONE;
            end
            S_POW_CHK: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.cnt_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = MS_ACC_SQ;
                    n_state         = S_POW_MUL;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = MS_SQ_SQ;
                    n_state         = S_POW_SQ;
                end
            end
            S_POW_MUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.op        = DP_MUL_ACC;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = MS_SQ_SQ;
                    n_state         = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                if (i_sts.mul_done) begin
                    o_cmd.op = DP_POW_SQ;
                    n_state  = S_POW_CHK;
                end
            end
            S_FACT_CHK: begin
                if (i_sts.fact_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = MS_ACC_CNT;
                    n_state         = S_FACT_MUL;
                end
            end
            S_FACT_MUL: begin
                if (i_sts.mul_done) begin
                    o_cmd.op = DP_FACT_NEXT;
                    n_state  = S_FACT_CHK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    a_accept_to_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SETUP))
        else $error("Accepted request did not move the controller to setup.");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> ((r_state == S_DONE) && (!r_out_valid || i_ready)))
        else $error("Output register loaded while it still held an unread result.");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("Output load did not raise valid and return to idle.");

    a_div_ends_in_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && i_sts.cnt_zero) |=> (r_state == S_DIV_FIX))
        else $error("Divider did not finish after its last step.");

endmodule

`default_nettype wire
